// File: rtl/imuwmc_pkg.sv
// Package for the IMU window mean/covariance block: sizes, codes, state type
// and index helpers. No dependencies.
`default_nettype none
package imuwmc_pkg;

  localparam int unsigned Depth   = 1024;
  localparam int unsigned AddrW   = $clog2(Depth);
  localparam int unsigned CntW    = AddrW + 1;
  localparam int unsigned SampW   = 16;
  localparam int unsigned RowW    = 6 * SampW;
  localparam int unsigned SumW    = SampW + AddrW + 1;
  localparam int unsigned ProdW   = 2 * SampW;
  localparam int unsigned PsumW   = ProdW + AddrW;
  localparam int unsigned NPW     = PsumW + CntW;
  localparam int unsigned NumW    = 56;
  localparam int unsigned DivW    = 64;
  localparam int unsigned DenW    = 20;
  localparam int unsigned ValW    = 48;
  localparam int unsigned CfgW    = 11;
  localparam logic [CfgW-1:0] WinReset = CfgW'(1000);
  localparam logic [CfgW-1:0] MinReset = CfgW'(10);

  localparam logic FuncStore  = 1'b0;
  localparam logic FuncFinish = 1'b1;

  typedef enum logic [1:0] {
    CFG_WINDOW_LEN = 2'd0,
    CFG_MIN_COUNT  = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_WALK,
    ST_LOAD,
    ST_MUL,
    ST_PREP,
    ST_DIV,
    ST_EMIT
  } state_e;

  // unique product index for an (r, c) pair of a symmetric 3x3 matrix
  function automatic logic [2:0] pair_idx(input logic [1:0] r, input logic [1:0] c);
    logic [1:0] lo;
    logic [1:0] hi;
    lo = (r < c) ? r : c;
    hi = (r < c) ? c : r;
    case ({lo, hi})
      4'b0000: pair_idx = 3'd0;
      4'b0001: pair_idx = 3'd1;
      4'b0010: pair_idx = 3'd2;
      4'b0101: pair_idx = 3'd3;
      4'b0110: pair_idx = 3'd4;
      4'b1010: pair_idx = 3'd5;
      default: pair_idx = 3'd0;
    endcase
  endfunction

  function automatic logic [1:0] pair_row(input logic [2:0] u);
    case (u)
      3'd0, 3'd1, 3'd2: pair_row = 2'd0;
      3'd3, 3'd4:       pair_row = 2'd1;
      3'd5:             pair_row = 2'd2;
      default:          pair_row = 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] pair_col(input logic [2:0] u);
    case (u)
      3'd0:       pair_col = 2'd0;
      3'd1, 3'd3: pair_col = 2'd1;
      3'd2, 3'd4, 3'd5: pair_col = 2'd2;
      default:    pair_col = 2'd0;
    endcase
  endfunction

endpackage
`default_nettype wire

// File: rtl/imu_window_mean_covariance.sv
// Top level of the IMU window mean/covariance block: sample store, walk,
// accumulators, serial multiplier and divider. Uses imuwmc_pkg and imuwmc_ram.
`default_nettype none
// A store request (func 0) never makes busy rise, so samples may arrive every
// clock while busy is low. A finish request (func 1) walks the n stored
// samples through the single read port of the sample RAM, then produces
// 24 results, each through a serial multiply (covariance only) and a
// restoring divider. Too few samples gives one error result on the cycle
// after the request. Results are shown for one cycle on result_valid_o and
// cannot be held off; busy stays high until the last one has gone.
module imu_window_mean_covariance (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        func_i,
  input  wire logic [15:0] accel_x_i,
  input  wire logic [15:0] accel_y_i,
  input  wire logic [15:0] accel_z_i,
  input  wire logic [15:0] gyro_x_i,
  input  wire logic [15:0] gyro_y_i,
  input  wire logic [15:0] gyro_z_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [10:0] cfg_data_i,
  output logic             result_valid_o,
  output logic             status_o,
  output logic             kind_o,
  output logic             sensor_o,
  output logic [1:0]       row_o,
  output logic [1:0]       col_o,
  output logic [47:0]      value_o,
  output logic [10:0]      sample_total_o,
  output logic             last_o
);

  localparam int unsigned AW = imuwmc_pkg::AddrW;
  localparam int unsigned CW = imuwmc_pkg::CntW;

  imuwmc_pkg::state_e state_q, state_d;

  logic [imuwmc_pkg::CfgW-1:0] win_q, min_q;
  logic [AW-1:0] wslot_q, start_q;
  logic [CW-1:0] count_q, n_q, rd_cnt_q;
  logic          rv_q, pv_q;

  logic signed [imuwmc_pkg::SampW-1:0] samp_q [6];
  logic signed [imuwmc_pkg::ProdW-1:0] prod_p_q [12];
  logic signed [imuwmc_pkg::SumW-1:0]  sum_q [6];
  logic signed [imuwmc_pkg::PsumW-1:0] psum_q [12];

  logic [imuwmc_pkg::DenW-1:0] den_q;
  logic        kind_q, sens_q;
  logic [1:0]  row_q, col_q;

  logic signed [imuwmc_pkg::NPW-1:0]  mcand_q, macc_q;
  logic [CW-1:0]                      nsh_q;
  logic [3:0]                         mcnt_q;
  logic signed [2*imuwmc_pkg::SumW-1:0] sxsy_q;

  logic [imuwmc_pkg::DivW-1:0] dvd_q;
  logic [imuwmc_pkg::DenW-1:0] rem_q;
  logic [5:0]                  dcnt_q;
  logic                        neg_q;

  logic [imuwmc_pkg::RowW-1:0] rdata;
  logic acc_store, acc_finish, too_few, walk_done, item_last, rd_en;
  logic [CW-1:0] cap, n_inc;
  logic [2:0] ax_r, ax_c, pu;
  logic [3:0] pidx;

  // ---------------- request handling
  assign acc_store  = start && !busy && (func_i == imuwmc_pkg::FuncStore);
  assign acc_finish = start && !busy && (func_i == imuwmc_pkg::FuncFinish);
  assign too_few    = (count_q < CW'(2)) || (count_q < min_q);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cap = win_q;
    if (win_q == '0) begin
      cap = CW'(1);
    end else if (win_q > CW'(imuwmc_pkg::Depth)) begin
      cap = CW'(imuwmc_pkg::Depth);
    end
    n_inc = count_q + CW'(1);
    if (n_inc > cap) begin
      n_inc = count_q;
    end
  end

  assign rd_en     = (state_q == imuwmc_pkg::ST_WALK) && (rd_cnt_q < n_q);
  assign walk_done = (rd_cnt_q == n_q) && !rv_q && !pv_q;
  assign item_last = kind_q && sens_q && (row_q == 2'd2) && (col_q == 2'd2);

  imuwmc_ram #(
    .Width(imuwmc_pkg::RowW),
    .Depth(imuwmc_pkg::Depth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (acc_store),
    .waddr_i(wslot_q),
    .wdata_i({gyro_z_i, gyro_y_i, gyro_x_i, accel_z_i, accel_y_i, accel_x_i}),
    .re_i   (rd_en),
    .raddr_i(start_q + rd_cnt_q[AW-1:0]),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= imuwmc_pkg::ST_IDLE;
      win_q    <= imuwmc_pkg::WinReset;
      min_q    <= imuwmc_pkg::MinReset;
      wslot_q  <= '0;
      count_q  <= '0;
      rd_cnt_q <= '0;
      rv_q     <= 1'b0;
      pv_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == imuwmc_pkg::CFG_WINDOW_LEN) begin
          win_q <= cfg_data_i;
        end else if (cfg_index_i == imuwmc_pkg::CFG_MIN_COUNT) begin
          min_q <= cfg_data_i;
        end
      end
      if (acc_store) begin
        wslot_q <= wslot_q + AW'(1);
        count_q <= n_inc;
      end
      if (acc_finish) begin
        count_q  <= '0;
        rd_cnt_q <= '0;
      end else if (rd_en) begin
        rd_cnt_q <= rd_cnt_q + CW'(1);
      end
      rv_q <= rd_en;
      pv_q <= rv_q;
    end
  end

  // ---------------- walk: products, then accumulate
  always_ff @(posedge clk_i) begin
    if (acc_finish) begin
      n_q     <= count_q;
      start_q <= wslot_q - count_q[AW-1:0];
      den_q   <= imuwmc_pkg::DenW'(count_q) * imuwmc_pkg::DenW'(count_q - CW'(1));
    end
    if (rv_q) begin
      for (int a = 0; a < 6; a++) begin
        samp_q[a] <= rdata[a*imuwmc_pkg::SampW +: imuwmc_pkg::SampW];
      end
      for (int s = 0; s < 2; s++) begin
        for (int u = 0; u < 6; u++) begin
          prod_p_q[s*6+u] <=
            $signed(rdata[(s*3+int'(imuwmc_pkg::pair_row(3'(u))))*imuwmc_pkg::SampW
                          +: imuwmc_pkg::SampW]) *
            $signed(rdata[(s*3+int'(imuwmc_pkg::pair_col(3'(u))))*imuwmc_pkg::SampW
                          +: imuwmc_pkg::SampW]);
        end
      end
    end
    if (acc_finish) begin
      for (int a = 0; a < 6; a++) begin
        sum_q[a] <= '0;
      end
      for (int j = 0; j < 12; j++) begin
        psum_q[j] <= '0;
      end
    end else if (pv_q) begin
      for (int a = 0; a < 6; a++) begin
        sum_q[a] <= sum_q[a] + imuwmc_pkg::SumW'(samp_q[a]);
      end
      for (int j = 0; j < 12; j++) begin
        psum_q[j] <= psum_q[j] + imuwmc_pkg::PsumW'(prod_p_q[j]);
      end
    end
  end

  // ---------------- per-result arithmetic
  assign ax_r = sens_q ? (3'd3 + 3'(row_q)) : 3'(row_q);
  assign ax_c = sens_q ? (3'd3 + 3'(col_q)) : 3'(col_q);
  assign pu   = imuwmc_pkg::pair_idx(row_q, col_q);
  assign pidx = (sens_q ? 4'd6 : 4'd0) + {1'b0, pu};

  logic signed [imuwmc_pkg::NumW-1:0] cov_num;
  logic signed [imuwmc_pkg::DivW-1:0] num64;
  logic [imuwmc_pkg::DenW:0]          trial;
  logic [imuwmc_pkg::DenW-1:0]        dsel;
  logic                               ge;

  assign cov_num = imuwmc_pkg::NumW'(macc_q) - imuwmc_pkg::NumW'(sxsy_q);
  assign num64   = kind_q ? {cov_num, 8'd0} :
                   {{(imuwmc_pkg::DivW-imuwmc_pkg::SumW-8){sum_q[ax_r][imuwmc_pkg::SumW-1]}},
                    sum_q[ax_r], 8'd0};
  assign dsel  = kind_q ? den_q : imuwmc_pkg::DenW'(n_q);
  assign trial = {rem_q, dvd_q[imuwmc_pkg::DivW-1]};
  assign ge    = trial >= {1'b0, dsel};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= 1'b0;
      sens_q <= 1'b0;
      row_q  <= '0;
      col_q  <= '0;
      mcnt_q <= '0;
      dcnt_q <= '0;
    end else begin
      if (acc_finish) begin
        kind_q <= 1'b0;
        sens_q <= 1'b0;
        row_q  <= '0;
        col_q  <= '0;
      end else if (state_q == imuwmc_pkg::ST_EMIT) begin
        if (!kind_q) begin
          if (row_q == 2'd2) begin
            row_q <= '0;
            if (sens_q) begin
              kind_q <= 1'b1;
              sens_q <= 1'b0;
            end else begin
              sens_q <= 1'b1;
            end
          end else begin
            row_q <= row_q + 2'd1;
          end
        end else if (col_q == 2'd2) begin
          col_q <= '0;
          if (row_q == 2'd2) begin
            row_q  <= '0;
            sens_q <= 1'b1;
          end else begin
            row_q <= row_q + 2'd1;
          end
        end else begin
          col_q <= col_q + 2'd1;
        end
      end
      if (state_q == imuwmc_pkg::ST_LOAD) begin
        mcnt_q <= '0;
      end else if (state_q == imuwmc_pkg::ST_MUL) begin
        mcnt_q <= mcnt_q + 4'd1;
      end
      if (state_q == imuwmc_pkg::ST_PREP) begin
        dcnt_q <= '0;
      end else if (state_q == imuwmc_pkg::ST_DIV) begin
        dcnt_q <= dcnt_q + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      imuwmc_pkg::ST_LOAD: begin
        mcand_q <= imuwmc_pkg::NPW'(psum_q[pidx]);
        nsh_q   <= n_q;
        macc_q  <= '0;
        sxsy_q  <= sum_q[ax_r] * sum_q[ax_c];
      end
      imuwmc_pkg::ST_MUL: begin
        if (nsh_q[0]) begin
          macc_q <= macc_q + mcand_q;
        end
        mcand_q <= mcand_q <<< 1;
        nsh_q   <= nsh_q >> 1;
      end
      imuwmc_pkg::ST_PREP: begin
        neg_q <= num64[imuwmc_pkg::DivW-1];
        dvd_q <= num64[imuwmc_pkg::DivW-1] ? (-num64) : num64;
        rem_q <= '0;
      end
      imuwmc_pkg::ST_DIV: begin
        rem_q <= ge ? imuwmc_pkg::DenW'(trial - {1'b0, dsel}) : trial[imuwmc_pkg::DenW-1:0];
        dvd_q <= {dvd_q[imuwmc_pkg::DivW-2:0], ge};
      end
      default: begin
      end
    endcase
  end

  // ---------------- sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      imuwmc_pkg::ST_IDLE: begin
        if (acc_finish) begin
          state_d = too_few ? imuwmc_pkg::ST_ERR : imuwmc_pkg::ST_WALK;
        end
      end
      imuwmc_pkg::ST_ERR:  state_d = imuwmc_pkg::ST_IDLE;
      imuwmc_pkg::ST_WALK: begin
        if (walk_done) begin
          state_d = imuwmc_pkg::ST_LOAD;
        end
      end
      imuwmc_pkg::ST_LOAD: state_d = kind_q ? imuwmc_pkg::ST_MUL : imuwmc_pkg::ST_PREP;
      imuwmc_pkg::ST_MUL: begin
        if (mcnt_q == 4'(CW - 1)) begin
          state_d = imuwmc_pkg::ST_PREP;
        end
      end
      imuwmc_pkg::ST_PREP: state_d = imuwmc_pkg::ST_DIV;
      imuwmc_pkg::ST_DIV: begin
        if (dcnt_q == 6'd63) begin
          state_d = imuwmc_pkg::ST_EMIT;
        end
      end
      imuwmc_pkg::ST_EMIT: state_d = item_last ? imuwmc_pkg::ST_IDLE : imuwmc_pkg::ST_LOAD;
      default: state_d = imuwmc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy           = (state_q != imuwmc_pkg::ST_IDLE);
    result_valid_o = (state_q == imuwmc_pkg::ST_EMIT) || (state_q == imuwmc_pkg::ST_ERR);
    status_o       = (state_q == imuwmc_pkg::ST_ERR);
    kind_o         = kind_q;
    sensor_o       = sens_q;
    row_o          = row_q;
    col_o          = col_q;
    sample_total_o = n_q;
    value_o        = '0;
    last_o         = 1'b0;
    case (state_q)
      imuwmc_pkg::ST_ERR: begin
        last_o = 1'b1;
      end
      imuwmc_pkg::ST_EMIT: begin
        value_o = neg_q ? (-dvd_q[imuwmc_pkg::ValW-1:0]) : dvd_q[imuwmc_pkg::ValW-1:0];
        last_o  = item_last;
      end
      default: begin
      end
    endcase
  end

  // ---------------- checks
  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy) else $error("result outside a finish");
  a_finish_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_finish |=> busy && (count_q == '0)) else $error("finish not taken");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |=> !result_valid_o && !busy) else $error("run overran");
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(imuwmc_pkg::Depth)) else $error("count above depth");

endmodule
`default_nettype wire

// File: rtl/imuwmc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module imuwmc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: sim/imu_window_mean_covariance_tb.sv
// Testbench for imu_window_mean_covariance: directed and random store/finish
// requests, checked against an in-bench predictor of mean and covariance.
// Depends on imuwmc_pkg and the block's RTL.
`timescale 1ns / 1ps
module imu_window_mean_covariance_tb;

  localparam logic [1:0] CfgSpareA = 2'd2;
  localparam logic [1:0] CfgSpareB = 2'd3;
  localparam int unsigned CycleLimit = 2000000;

  typedef struct {
    logic        status;
    logic        kind;
    logic        sensor;
    logic [1:0]  row;
    logic [1:0]  col;
    logic [47:0] value;
    logic [10:0] total;
    logic        last;
  } stat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic func_i = imuwmc_pkg::FuncStore;
  logic [15:0] accel_x_i = '0, accel_y_i = '0, accel_z_i = '0;
  logic [15:0] gyro_x_i = '0, gyro_y_i = '0, gyro_z_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [10:0] cfg_data_i = '0;
  logic result_valid_o, status_o, kind_o, sensor_o, last_o;
  logic [1:0] row_o, col_o;
  logic [47:0] value_o;
  logic [10:0] sample_total_o;

  logic [95:0] window_samples[$];
  stat_t pending_stats[$];
  logic [10:0] win_len;
  logic [10:0] min_cnt;
  int errors = 0;
  int cycles = 0;
  int burst_left = 0;

  imu_window_mean_covariance uut (
    .clk_i, .rst_ni, .start, .busy, .func_i,
    .accel_x_i, .accel_y_i, .accel_z_i, .gyro_x_i, .gyro_y_i, .gyro_z_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .result_valid_o, .status_o, .kind_o, .sensor_o, .row_o, .col_o,
    .value_o, .sample_total_o, .last_o
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    stat_t e;
    if (rst_ni && result_valid_o) begin
      if (pending_stats.size() == 0) begin
        $display("%0t unexpected result: expected none, actual value %0h", $time, value_o);
        errors++;
      end else begin
        e = pending_stats.pop_front();
        if ({status_o, kind_o, sensor_o, row_o, col_o, value_o, sample_total_o, last_o} !==
            {e.status, e.kind, e.sensor, e.row, e.col, e.value, e.total, e.last}) begin
          $display("%0t mismatch: expected st%0b k%0b s%0b r%0d c%0d v%0h n%0d l%0b",
                   $time, e.status, e.kind, e.sensor, e.row, e.col, e.value, e.total,
                   e.last);
          $display("%0t            actual st%0b k%0b s%0b r%0d c%0d v%0h n%0d l%0b",
                   $time, status_o, kind_o, sensor_o, row_o, col_o, value_o,
                   sample_total_o, last_o);
          errors++;
        end
      end
    end
  end

  function automatic stat_t mk_stat(logic st, logic k, logic s, logic [1:0] r,
                                    logic [1:0] c, longint v, int n, logic l);
    stat_t t;
    t.status = st; t.kind = k; t.sensor = s; t.row = r; t.col = c;
    t.value = v[47:0]; t.total = n[10:0]; t.last = l;
    return t;
  endfunction

  task automatic predict_window_stats(input logic fn, input logic [95:0] smp);
    int cap;
    int n;
    longint sum[6];
    longint prod[2][3][3];
    longint v;
    logic [95:0] e;
    if (fn == imuwmc_pkg::FuncStore) begin
      cap = (win_len == 0) ? 1 : (win_len > imuwmc_pkg::Depth) ? imuwmc_pkg::Depth : win_len;
      window_samples.insert(window_samples.size(), smp);
      if (window_samples.size() > cap) void'(window_samples.pop_front());
      return;
    end
    n = window_samples.size();
    if (n < 2 || n < min_cnt) begin
      window_samples.delete();
      pending_stats.insert(pending_stats.size(), mk_stat(1, 0, 0, 0, 0, 0, n, 1));
      return;
    end
    foreach (sum[i]) sum[i] = 0;
    foreach (prod[s, r, c]) prod[s][r][c] = 0;
    foreach (window_samples[i]) begin
      e = window_samples[i];
      for (int s = 0; s < 2; s++)
        for (int r = 0; r < 3; r++) begin
          sum[s*3+r] += longint'($signed(e[(s*3+r)*16 +: 16]));
          for (int c = 0; c < 3; c++)
            prod[s][r][c] += longint'($signed(e[(s*3+r)*16 +: 16])) *
                             longint'($signed(e[(s*3+c)*16 +: 16]));
        end
    end
    window_samples.delete();
    for (int s = 0; s < 2; s++)
      for (int r = 0; r < 3; r++)
        pending_stats.insert(pending_stats.size(),
                             mk_stat(0, 0, s, r, 0, (sum[s*3+r] * 256) / n, n, 0));
    for (int s = 0; s < 2; s++)
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++) begin
          v = ((longint'(n) * prod[s][r][c] - sum[s*3+r] * sum[s*3+c]) * 256) /
              (longint'(n) * longint'(n - 1));
          pending_stats.insert(pending_stats.size(),
                               mk_stat(0, 1, s, r, c, v, n, s == 1 && r == 2 && c == 2));
        end
  endtask

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(signed'($urandom_range(0, 40)) - 20);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [95:0] rand_sample();
    logic [95:0] d;
    for (int a = 0; a < 6; a++) d[a*16 +: 16] = rand_axis();
    return d;
  endfunction

  // one request; start stays high on return so back-to-back requests need no re-raise
  task automatic send_req(input logic fn, input logic [95:0] d);
    start <= 1'b1;
    func_i <= fn;
    {gyro_z_i, gyro_y_i, gyro_x_i, accel_z_i, accel_y_i, accel_x_i} <= d;
    do @(posedge clk_i); while (busy);
    predict_window_stats(fn, d);
  endtask

  task automatic paced_req(input logic fn, input logic [95:0] d);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
    end
    burst_left--;
    send_req(fn, d);
  endtask

  task automatic wait_quiet();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_stats.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [10:0] d);
    wait_quiet();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == imuwmc_pkg::CFG_WINDOW_LEN) win_len = d;
    else if (idx == imuwmc_pkg::CFG_MIN_COUNT) min_cnt = d;
  endtask

  task automatic store_n(input int n);
    repeat (n) paced_req(imuwmc_pkg::FuncStore, rand_sample());
  endtask

  task automatic test_reset_defaults();
    store_n(3);
    send_req(imuwmc_pkg::FuncFinish, rand_sample());
  endtask

  task automatic test_extremes();
    write_reg(imuwmc_pkg::CFG_MIN_COUNT, 11'd2);
    send_req(imuwmc_pkg::FuncStore, {6{16'h8000}});
    send_req(imuwmc_pkg::FuncStore, {6{16'h7fff}});
    send_req(imuwmc_pkg::FuncStore,
             {16'h7fff, 16'h8000, 16'hffff, 16'h0000, 16'h8000, 16'h7fff});
    send_req(imuwmc_pkg::FuncStore, {6{16'h0000}});
    send_req(imuwmc_pkg::FuncFinish, {6{16'hffff}});
    send_req(imuwmc_pkg::FuncFinish, '0);
    send_req(imuwmc_pkg::FuncStore, {6{16'h1234}});
    send_req(imuwmc_pkg::FuncFinish, '0);
  endtask

  task automatic test_window_limits();
    write_reg(imuwmc_pkg::CFG_WINDOW_LEN, 11'd0);
    store_n(3);
    send_req(imuwmc_pkg::FuncFinish, '0);
    write_reg(imuwmc_pkg::CFG_WINDOW_LEN, 11'd4);
    store_n(4);
    write_reg(imuwmc_pkg::CFG_WINDOW_LEN, 11'd2);
    write_reg(CfgSpareA, 11'h7ff);
    write_reg(CfgSpareB, 11'h000);
    store_n(1);
    send_req(imuwmc_pkg::FuncFinish, '0);
  endtask

  task automatic test_random();
    int burst;
    for (int ph = 0; ph < 15; ph++) begin
      case ($urandom_range(0, 5))
        0: write_reg(imuwmc_pkg::CFG_WINDOW_LEN, 11'h7ff);
        1: write_reg(imuwmc_pkg::CFG_WINDOW_LEN, 11'd1024);
        2: write_reg(imuwmc_pkg::CFG_WINDOW_LEN, 11'd2);
        default: write_reg(imuwmc_pkg::CFG_WINDOW_LEN, 11'($urandom_range(1, 40)));
      endcase
      case ($urandom_range(0, 5))
        0: write_reg(imuwmc_pkg::CFG_MIN_COUNT, 11'd0);
        1: write_reg(imuwmc_pkg::CFG_MIN_COUNT, 11'd1024);
        2: write_reg(imuwmc_pkg::CFG_MIN_COUNT, 11'h7ff);
        default: write_reg(imuwmc_pkg::CFG_MIN_COUNT, 11'($urandom_range(2, 12)));
      endcase
      for (int b = 0; b < 3; b++) begin
        burst = $urandom_range(0, 4) == 0 ? $urandom_range(0, 3) : $urandom_range(2, 12);
        store_n(burst);
        paced_req(imuwmc_pkg::FuncFinish, rand_sample());
      end
    end
  endtask

  initial begin
    win_len = imuwmc_pkg::WinReset;
    min_cnt = imuwmc_pkg::MinReset;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_extremes();
    test_window_limits();
    test_random();
    wait_quiet();
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
